// File: sv/ray_triangle_closest_hit_defines.svh
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_defines
// assertion macros shared by the ray / triangle nearest-hit block
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RTCH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RTCH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rtch_pkg.sv
// ----------------------------------------------------------------------------
// rtch_pkg
// widths, codes, command and status types and the multiply-accumulate
// microcode of the ray / triangle nearest-hit block
// ----------------------------------------------------------------------------
package rtch_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;                // coordinate width
    localparam int EW        = CW + 1;            // edge / difference width
    localparam int PW        = 2 * EW + 1;        // cross product width
    localparam int LOW       = (PW + 1) / 2;      // low slice of a cross product
    localparam int MBW       = LOW + 1;           // multiplier b operand width
    localparam int PRW       = EW + MBW;          // product width
    localparam int DW        = PRW + LOW;         // dot product width
    localparam int TQW       = 31;                // distance quotient width
    localparam int UQW       = FRAC_BITS + 1;     // barycentric quotient width
    localparam int REMW      = DW + TQW + 1;      // divider remainder width
    localparam int FACE_W    = 16;
    localparam int CNTW      = $clog2(TQW);

    // smallest accepted |det|: det * 1e8 >= 2^(3*FRAC_BITS)
    localparam logic [127:0] DET_MIN_W =
        ((128'd1 << (3 * FRAC_BITS)) + 128'd99999999) / 128'd100000000;
    localparam logic [DW-1:0] DET_MIN = DW'(DET_MIN_W);

    // microcode length
    localparam int NSTEP = 36;
    localparam int SW    = $clog2(NSTEP);
    localparam logic [SW-1:0] LAST_STEP = SW'(NSTEP - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAXD  = 3'd6;

    // vector components
    localparam logic [1:0] CX = 2'd0;
    localparam logic [1:0] CY = 2'd1;
    localparam logic [1:0] CZ = 2'd2;

    typedef enum logic [1:0] {VA_DIR, VA_E1, VA_E2, VA_S} vec_a_t;
    typedef enum logic [1:0] {VB_E1, VB_E2, VB_H, VB_Q} vec_b_t;
    typedef enum logic [1:0] {PT_FULL, PT_LO, PT_HI} part_t;
    typedef enum logic [2:0] {DS_H, DS_Q, DS_DET, DS_UN, DS_VN, DS_TN} dst_t;
    typedef enum logic [1:0] {DV_T, DV_U, DV_V} div_sel_t;

    typedef struct packed {
        vec_a_t     a_vec;
        logic [1:0] a_comp;
        vec_b_t     b_vec;
        logic [1:0] b_comp;
        part_t      part;
        logic       sub;
        logic       last;
        dst_t       dst;
        logic [1:0] dst_comp;
    } uop_t;

    typedef struct packed {
        logic          load;
        logic          issue;
        logic [SW-1:0] step;
        logic          norm;
        logic          div_init;
        div_sel_t      div_sel;
        logic          div_step;
        logic          cap_t;
        logic          cap_u;
        logic          update;
        logic          out_load;
    } cmd_t;

    typedef struct packed {
        logic geo_reject;
        logic t_reject;
        logic final_tri;
        logic out_free;
    } stat_t;

    function automatic uop_t mk(vec_a_t av, logic [1:0] ac, vec_b_t bv, logic [1:0] bc,
                                part_t pt, logic sb, logic ls, dst_t d, logic [1:0] dc);
        uop_t u;
        u.a_vec    = av;
        u.a_comp   = ac;
        u.b_vec    = bv;
        u.b_comp   = bc;
        u.part     = pt;
        u.sub      = sb;
        u.last     = ls;
        u.dst      = d;
        u.dst_comp = dc;
        return u;
    endfunction

    // h = dir x e2, q = s x e1, then det, un, vn, tn as dot products
    function automatic uop_t uop_at(logic [SW-1:0] step);
        uop_t u;
        case (step)
            6'd0:  u = mk(VA_DIR, CY, VB_E2, CZ, PT_FULL, 1'b0, 1'b0, DS_H, CX);
            6'd1:  u = mk(VA_DIR, CZ, VB_E2, CY, PT_FULL, 1'b1, 1'b1, DS_H, CX);
            6'd2:  u = mk(VA_DIR, CZ, VB_E2, CX, PT_FULL, 1'b0, 1'b0, DS_H, CY);
            6'd3:  u = mk(VA_DIR, CX, VB_E2, CZ, PT_FULL, 1'b1, 1'b1, DS_H, CY);
            6'd4:  u = mk(VA_DIR, CX, VB_E2, CY, PT_FULL, 1'b0, 1'b0, DS_H, CZ);
            6'd5:  u = mk(VA_DIR, CY, VB_E2, CX, PT_FULL, 1'b1, 1'b1, DS_H, CZ);
            6'd6:  u = mk(VA_S,   CY, VB_E1, CZ, PT_FULL, 1'b0, 1'b0, DS_Q, CX);
            6'd7:  u = mk(VA_S,   CZ, VB_E1, CY, PT_FULL, 1'b1, 1'b1, DS_Q, CX);
            6'd8:  u = mk(VA_S,   CZ, VB_E1, CX, PT_FULL, 1'b0, 1'b0, DS_Q, CY);
            6'd9:  u = mk(VA_S,   CX, VB_E1, CZ, PT_FULL, 1'b1, 1'b1, DS_Q, CY);
            6'd10: u = mk(VA_S,   CX, VB_E1, CY, PT_FULL, 1'b0, 1'b0, DS_Q, CZ);
            6'd11: u = mk(VA_S,   CY, VB_E1, CX, PT_FULL, 1'b1, 1'b1, DS_Q, CZ);
            6'd12: u = mk(VA_E1,  CX, VB_H,  CX, PT_LO,   1'b0, 1'b0, DS_DET, CX);
            6'd13: u = mk(VA_E1,  CX, VB_H,  CX, PT_HI,   1'b0, 1'b0, DS_DET, CX);
            6'd14: u = mk(VA_E1,  CY, VB_H,  CY, PT_LO,   1'b0, 1'b0, DS_DET, CX);
            6'd15: u = mk(VA_E1,  CY, VB_H,  CY, PT_HI,   1'b0, 1'b0, DS_DET, CX);
            6'd16: u = mk(VA_E1,  CZ, VB_H,  CZ, PT_LO,   1'b0, 1'b0, DS_DET, CX);
            6'd17: u = mk(VA_E1,  CZ, VB_H,  CZ, PT_HI,   1'b0, 1'b1, DS_DET, CX);
            6'd18: u = mk(VA_S,   CX, VB_H,  CX, PT_LO,   1'b0, 1'b0, DS_UN, CX);
            6'd19: u = mk(VA_S,   CX, VB_H,  CX, PT_HI,   1'b0, 1'b0, DS_UN, CX);
            6'd20: u = mk(VA_S,   CY, VB_H,  CY, PT_LO,   1'b0, 1'b0, DS_UN, CX);
            6'd21: u = mk(VA_S,   CY, VB_H,  CY, PT_HI,   1'b0, 1'b0, DS_UN, CX);
            6'd22: u = mk(VA_S,   CZ, VB_H,  CZ, PT_LO,   1'b0, 1'b0, DS_UN, CX);
            6'd23: u = mk(VA_S,   CZ, VB_H,  CZ, PT_HI,   1'b0, 1'b1, DS_UN, CX);
            6'd24: u = mk(VA_DIR, CX, VB_Q,  CX, PT_LO,   1'b0, 1'b0, DS_VN, CX);
            6'd25: u = mk(VA_DIR, CX, VB_Q,  CX, PT_HI,   1'b0, 1'b0, DS_VN, CX);
            6'd26: u = mk(VA_DIR, CY, VB_Q,  CY, PT_LO,   1'b0, 1'b0, DS_VN, CX);
            6'd27: u = mk(VA_DIR, CY, VB_Q,  CY, PT_HI,   1'b0, 1'b0, DS_VN, CX);
            6'd28: u = mk(VA_DIR, CZ, VB_Q,  CZ, PT_LO,   1'b0, 1'b0, DS_VN, CX);
            6'd29: u = mk(VA_DIR, CZ, VB_Q,  CZ, PT_HI,   1'b0, 1'b1, DS_VN, CX);
            6'd30: u = mk(VA_E2,  CX, VB_Q,  CX, PT_LO,   1'b0, 1'b0, DS_TN, CX);
            6'd31: u = mk(VA_E2,  CX, VB_Q,  CX, PT_HI,   1'b0, 1'b0, DS_TN, CX);
            6'd32: u = mk(VA_E2,  CY, VB_Q,  CY, PT_LO,   1'b0, 1'b0, DS_TN, CX);
            6'd33: u = mk(VA_E2,  CY, VB_Q,  CY, PT_HI,   1'b0, 1'b0, DS_TN, CX);
            6'd34: u = mk(VA_E2,  CZ, VB_Q,  CZ, PT_LO,   1'b0, 1'b0, DS_TN, CX);
            6'd35: u = mk(VA_E2,  CZ, VB_Q,  CZ, PT_HI,   1'b0, 1'b1, DS_TN, CX);
            default: u = mk(VA_DIR, CX, VB_E1, CX, PT_FULL, 1'b0, 1'b0, DS_H, CX);
        endcase
        return u;
    endfunction

endpackage

// File: sv/ray_triangle_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// nearest ray / triangle hit over a stream of triangles (fixed-point
// Moller-Trumbore test)
// ----------------------------------------------------------------------------
// usage
//   the ray origin, direction and maximum distance are written on the cfg
//   port (cfg_we, cfg_index, cfg_wdata) while the block is idle
//   triangles arrive on the in channel (in_valid / in_ready), one transfer
//   each; the last triangle of a mesh carries final_triangle
//   on a final triangle one result goes out on the out channel
//   (out_valid / out_ready) and the kept hit is cleared
//   a triangle that passes every test takes longer from transfer to
//   readiness for the next than one rejected early; the cost is set by
//   the single shared 33 x 35 multiplier (36 products) and the one-bit-per-
//   cycle restoring divider (31 + 17 + 17 quotient bits)
//   out_valid rises once the final triangle is done, held back only
//   while the previous result still waits in the output register
//   the result sits in an output register, so the next triangle is taken
//   while a result waits; a second final triangle waits until it has gone
//   reset clears the kept hit, the output register and loads the default ray
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rtch_pkg::CW-1:0]               cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [rtch_pkg::CW-1:0]        ax,
    input  logic signed [rtch_pkg::CW-1:0]        ay,
    input  logic signed [rtch_pkg::CW-1:0]        az,
    input  logic signed [rtch_pkg::CW-1:0]        bx,
    input  logic signed [rtch_pkg::CW-1:0]        by,
    input  logic signed [rtch_pkg::CW-1:0]        bz,
    input  logic signed [rtch_pkg::CW-1:0]        cx,
    input  logic signed [rtch_pkg::CW-1:0]        cy,
    input  logic signed [rtch_pkg::CW-1:0]        cz,
    input  logic [rtch_pkg::FACE_W-1:0]           face_tag,
    input  logic                                  final_triangle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit_found,
    output logic [rtch_pkg::TQW-1:0]              hit_distance,
    output logic [rtch_pkg::UQW-1:0]              bary_u,
    output logic [rtch_pkg::UQW-1:0]              bary_v,
    output logic [rtch_pkg::FACE_W-1:0]           hit_face
);

    rtch_pkg::cmd_t  cmd;
    rtch_pkg::stat_t stat;

    // sequencer
    rtch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    rtch_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .ax             (ax),
        .ay             (ay),
        .az             (az),
        .bx             (bx),
        .by             (by),
        .bz             (bz),
        .cx             (cx),
        .cy             (cy),
        .cz             (cz),
        .face_tag       (face_tag),
        .final_triangle (final_triangle),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .hit_found      (hit_found),
        .hit_distance   (hit_distance),
        .bary_u         (bary_u),
        .bary_v         (bary_v),
        .hit_face       (hit_face)
    );

endmodule

// File: sv/rtch_dpath.sv
// ----------------------------------------------------------------------------
// rtch_dpath
// datapath: ray registers, edge vectors, shared multiply-accumulate,
// restoring divider, nearest-hit store and output register
// ----------------------------------------------------------------------------
module rtch_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rtch_pkg::CW-1:0]               cfg_wdata,
    input  logic signed [rtch_pkg::CW-1:0]        ax,
    input  logic signed [rtch_pkg::CW-1:0]        ay,
    input  logic signed [rtch_pkg::CW-1:0]        az,
    input  logic signed [rtch_pkg::CW-1:0]        bx,
    input  logic signed [rtch_pkg::CW-1:0]        by,
    input  logic signed [rtch_pkg::CW-1:0]        bz,
    input  logic signed [rtch_pkg::CW-1:0]        cx,
    input  logic signed [rtch_pkg::CW-1:0]        cy,
    input  logic signed [rtch_pkg::CW-1:0]        cz,
    input  logic [rtch_pkg::FACE_W-1:0]           face_tag,
    input  logic                                  final_triangle,
    input  rtch_pkg::cmd_t                        cmd,
    output rtch_pkg::stat_t                       stat,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  hit_found,
    output logic [rtch_pkg::TQW-1:0]              hit_distance,
    output logic [rtch_pkg::UQW-1:0]              bary_u,
    output logic [rtch_pkg::UQW-1:0]              bary_v,
    output logic [rtch_pkg::FACE_W-1:0]           hit_face
);

    // ray registers
    logic [2:0][rtch_pkg::CW-1:0]  org_reg;
    logic [2:0][rtch_pkg::CW-1:0]  dir_reg;
    logic [rtch_pkg::TQW-1:0]      maxd_reg;

    // per-triangle vectors and sums
    logic [2:0][rtch_pkg::EW-1:0]  e1_reg, e2_reg, s_reg;
    logic [2:0][rtch_pkg::PW-1:0]  h_reg, q_reg;
    logic [rtch_pkg::DW-1:0]       det_reg, un_reg, vn_reg, tn_reg;
    logic [rtch_pkg::FACE_W-1:0]   face_reg;
    logic                          final_reg;

    // multiply-accumulate
    rtch_pkg::uop_t                uop;
    logic [2:0][rtch_pkg::EW-1:0]  dir_ext;
    logic [2:0][rtch_pkg::EW-1:0]  a_row;
    logic [2:0][rtch_pkg::EW-1:0]  bs_row;
    logic [2:0][rtch_pkg::PW-1:0]  bw_row;
    logic [rtch_pkg::EW-1:0]       bs_op;
    logic [rtch_pkg::PW-1:0]       bw_op;
    logic signed [rtch_pkg::EW-1:0]  a_op;
    logic signed [rtch_pkg::MBW-1:0] b_op;
    logic signed [rtch_pkg::PRW-1:0] prod_next, prod_reg;
    logic                          mac_v_reg;
    rtch_pkg::uop_t                muop_reg;
    logic signed [rtch_pkg::DW-1:0]  acc_reg, prod_ext, term, sum;

    // divider
    logic [rtch_pkg::REMW-1:0]     rem_reg, den_reg;
    logic [rtch_pkg::TQW-1:0]      quo_reg, tq_reg;
    logic [rtch_pkg::UQW-1:0]      uq_reg;
    logic [rtch_pkg::DW-1:0]       div_num;

    // nearest hit and output register
    logic                          best_found_reg;
    logic [rtch_pkg::TQW-1:0]      best_t_reg;
    logic [rtch_pkg::UQW-1:0]      best_u_reg, best_v_reg;
    logic [rtch_pkg::FACE_W-1:0]   best_face_reg;
    logic                          out_valid_reg;

    // checks
    logic [rtch_pkg::DW:0]         uv_sum;
    logic [rtch_pkg::REMW-1:0]     t_far_lim;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg  <= '0;
            dir_reg  <= {rtch_pkg::CW'(0), rtch_pkg::CW'(0),
                         rtch_pkg::CW'(1 << rtch_pkg::FRAC_BITS)};
            maxd_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtch_pkg::REG_ORG_X: org_reg[0] <= cfg_wdata;
                rtch_pkg::REG_ORG_Y: org_reg[1] <= cfg_wdata;
                rtch_pkg::REG_ORG_Z: org_reg[2] <= cfg_wdata;
                rtch_pkg::REG_DIR_X: dir_reg[0] <= cfg_wdata;
                rtch_pkg::REG_DIR_Y: dir_reg[1] <= cfg_wdata;
                rtch_pkg::REG_DIR_Z: dir_reg[2] <= cfg_wdata;
                rtch_pkg::REG_MAXD:  maxd_reg   <= cfg_wdata[rtch_pkg::TQW-1:0];
                default: ;
            endcase
        end
    end

    // triangle capture: edges and origin offset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e1_reg[0] <= rtch_pkg::EW'(bx) - rtch_pkg::EW'(ax);
            e1_reg[1] <= rtch_pkg::EW'(by) - rtch_pkg::EW'(ay);
            e1_reg[2] <= rtch_pkg::EW'(bz) - rtch_pkg::EW'(az);
            e2_reg[0] <= rtch_pkg::EW'(cx) - rtch_pkg::EW'(ax);
            e2_reg[1] <= rtch_pkg::EW'(cy) - rtch_pkg::EW'(ay);
            e2_reg[2] <= rtch_pkg::EW'(cz) - rtch_pkg::EW'(az);
            s_reg[0]  <= rtch_pkg::EW'(signed'(org_reg[0])) - rtch_pkg::EW'(ax);
            s_reg[1]  <= rtch_pkg::EW'(signed'(org_reg[1])) - rtch_pkg::EW'(ay);
            s_reg[2]  <= rtch_pkg::EW'(signed'(org_reg[2])) - rtch_pkg::EW'(az);
            face_reg  <= face_tag;
            final_reg <= final_triangle;
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        uop = rtch_pkg::uop_at(cmd.step);
        for (int i = 0; i < 3; i++)
        begin
            dir_ext[i] = rtch_pkg::EW'(signed'(dir_reg[i]));
        end
        case (uop.a_vec)
            rtch_pkg::VA_DIR: a_row = dir_ext;
            rtch_pkg::VA_E1:  a_row = e1_reg;
            rtch_pkg::VA_E2:  a_row = e2_reg;
            rtch_pkg::VA_S:   a_row = s_reg;
            default:          a_row = dir_ext;
        endcase
        bs_row = (uop.b_vec == rtch_pkg::VB_E1) ? e1_reg : e2_reg;
        bw_row = (uop.b_vec == rtch_pkg::VB_H) ? h_reg : q_reg;
        a_op   = signed'(a_row[uop.a_comp]);
        bs_op  = bs_row[uop.b_comp];
        bw_op  = bw_row[uop.b_comp];
        case (uop.part)
            rtch_pkg::PT_FULL: b_op = rtch_pkg::MBW'(signed'(bs_op));
            rtch_pkg::PT_LO:   b_op = signed'({1'b0, bw_op[rtch_pkg::LOW-1:0]});
            rtch_pkg::PT_HI:   b_op = rtch_pkg::MBW'(signed'(bw_op[rtch_pkg::PW-1:rtch_pkg::LOW]));
            default:           b_op = '0;
        endcase
        prod_next = a_op * b_op;
    end

    // product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v_reg <= 1'b0;
        end
        else
        begin
            mac_v_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        muop_reg <= uop;
    end

    // accumulate stage
    always_comb
    begin
        prod_ext = rtch_pkg::DW'(prod_reg);
        term     = (muop_reg.part == rtch_pkg::PT_HI) ? (prod_ext <<< rtch_pkg::LOW) : prod_ext;
        sum      = muop_reg.sub ? (acc_reg - term) : (acc_reg + term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (mac_v_reg)
        begin
            acc_reg <= muop_reg.last ? '0 : sum;
        end
    end

    // result stores, then sign normalisation of det, un, vn and tn on a negative det
    always_ff @(posedge clk)
    begin
        if (mac_v_reg && muop_reg.last)
        begin
            case (muop_reg.dst)
                rtch_pkg::DS_H:   h_reg[muop_reg.dst_comp] <= sum[rtch_pkg::PW-1:0];
                rtch_pkg::DS_Q:   q_reg[muop_reg.dst_comp] <= sum[rtch_pkg::PW-1:0];
                rtch_pkg::DS_DET: det_reg <= sum;
                rtch_pkg::DS_UN:  un_reg  <= sum;
                rtch_pkg::DS_VN:  vn_reg  <= sum;
                rtch_pkg::DS_TN:  tn_reg  <= sum;
                default: ;
            endcase
        end
        else if (cmd.norm && det_reg[rtch_pkg::DW-1])
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
    end

    // geometry tests on the normalised sums
    always_comb
    begin
        uv_sum    = {1'b0, un_reg} + {1'b0, vn_reg};
        t_far_lim = rtch_pkg::REMW'(det_reg) << (rtch_pkg::TQW - rtch_pkg::FRAC_BITS);
        stat.geo_reject = (det_reg < rtch_pkg::DET_MIN)
                       || un_reg[rtch_pkg::DW-1] || (un_reg > det_reg)
                       || vn_reg[rtch_pkg::DW-1] || (uv_sum > {1'b0, det_reg})
                       || tn_reg[rtch_pkg::DW-1]
                       || (rtch_pkg::REMW'(tn_reg) >= t_far_lim);
        stat.t_reject   = (quo_reg == '0) || (quo_reg >= maxd_reg)
                       || (best_found_reg && (quo_reg >= best_t_reg));
        stat.final_tri  = final_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        case (cmd.div_sel)
            rtch_pkg::DV_T: div_num = tn_reg;
            rtch_pkg::DV_U: div_num = un_reg;
            rtch_pkg::DV_V: div_num = vn_reg;
            default:        div_num = tn_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= rtch_pkg::REMW'(div_num) << rtch_pkg::FRAC_BITS;
            quo_reg <= '0;
            if (cmd.div_sel == rtch_pkg::DV_T)
            begin
                den_reg <= rtch_pkg::REMW'(det_reg) << (rtch_pkg::TQW - 1);
            end
            else
            begin
                den_reg <= rtch_pkg::REMW'(det_reg) << (rtch_pkg::UQW - 1);
            end
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_reg <= rem_reg - den_reg;
                quo_reg <= {quo_reg[rtch_pkg::TQW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[rtch_pkg::TQW-2:0], 1'b0};
            end
            den_reg <= den_reg >> 1;
        end
        if (cmd.cap_t)
        begin
            tq_reg <= quo_reg;
        end
        if (cmd.cap_u)
        begin
            uq_reg <= quo_reg[rtch_pkg::UQW-1:0];
        end
    end

    // nearest hit store and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_t_reg     <= '0;
            best_u_reg     <= '0;
            best_v_reg     <= '0;
            best_face_reg  <= '0;
            out_valid_reg  <= 1'b0;
            hit_found      <= 1'b0;
            hit_distance   <= '0;
            bary_u         <= '0;
            bary_v         <= '0;
            hit_face       <= '0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                hit_found      <= best_found_reg;
                hit_distance   <= best_t_reg;
                bary_u         <= best_u_reg;
                bary_v         <= best_v_reg;
                hit_face       <= best_face_reg;
                best_found_reg <= 1'b0;
                best_t_reg     <= '0;
                best_u_reg     <= '0;
                best_v_reg     <= '0;
                best_face_reg  <= '0;
            end
            else
            begin
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (cmd.update)
                begin
                    best_found_reg <= 1'b1;
                    best_t_reg     <= tq_reg;
                    best_u_reg     <= uq_reg;
                    best_v_reg     <= quo_reg[rtch_pkg::UQW-1:0];
                    best_face_reg  <= face_reg;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/rtch_ctrl.sv
// ----------------------------------------------------------------------------
// rtch_ctrl
// controller: sequences capture, multiply-accumulate microcode, sign
// normalisation, the three divisions, the hit update and the result transfer
// ----------------------------------------------------------------------------
`include "ray_triangle_closest_hit_defines.svh"

module rtch_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rtch_pkg::stat_t stat,
    output rtch_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MAC    = 12'b0000_0000_0010,
        S_DRAIN  = 12'b0000_0000_0100,
        S_NORM   = 12'b0000_0000_1000,
        S_CHECK  = 12'b0000_0001_0000,
        S_DIVT   = 12'b0000_0010_0000,
        S_TEST   = 12'b0000_0100_0000,
        S_DIVU   = 12'b0000_1000_0000,
        S_CAPU   = 12'b0001_0000_0000,
        S_DIVV   = 12'b0010_0000_0000,
        S_UPDATE = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } state_t;

    localparam logic [rtch_pkg::CNTW-1:0] T_LAST = rtch_pkg::CNTW'(rtch_pkg::TQW - 1);
    localparam logic [rtch_pkg::CNTW-1:0] U_LAST = rtch_pkg::CNTW'(rtch_pkg::UQW - 1);

    state_t                      state_reg, state_next;
    logic [rtch_pkg::SW-1:0]     step_reg, step_next;
    logic [rtch_pkg::CNTW-1:0]   cnt_reg, cnt_next;

    // state, microcode step and divider bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.issue = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == rtch_pkg::LAST_STEP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.geo_reject)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cmd.div_sel  = rtch_pkg::DV_T;
                    cnt_next     = '0;
                    state_next   = S_DIVT;
                end
            end
            S_DIVT:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == T_LAST)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                cmd.cap_t = 1'b1;
                if (stat.t_reject)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cmd.div_sel  = rtch_pkg::DV_U;
                    cnt_next     = '0;
                    state_next   = S_DIVU;
                end
            end
            S_DIVU:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == U_LAST)
                begin
                    state_next = S_CAPU;
                end
            end
            S_CAPU:
            begin
                cmd.cap_u    = 1'b1;
                cmd.div_init = 1'b1;
                cmd.div_sel  = rtch_pkg::DV_V;
                cnt_next     = '0;
                state_next   = S_DIVV;
            end
            S_DIVV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == U_LAST)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.final_tri)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    `RTCH_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == S_MAC, step_reg <= rtch_pkg::LAST_STEP, "microcode step past end")
    `RTCH_ASSERT_NXT(a_accept_mac, clk, rst_n, in_valid && in_ready, state_reg == S_MAC && step_reg == '0, "transfer did not start the microcode")
    `RTCH_ASSERT_IMP(a_out_free, clk, rst_n, cmd.out_load, stat.out_free, "result loaded over a pending transfer")
    `RTCH_ASSERT_IMP(a_div_count, clk, rst_n, state_reg == S_DIVU || state_reg == S_DIVV, cnt_reg <= U_LAST, "divider count overrun")

endmodule

// File: bench/ray_triangle_closest_hit_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_tb
// self-checking bench for the nearest-hit ray / triangle unit: a directed
// table of corner cases, then phases of random rays with meshes built
// around each ray, every result checked against a typed expectation
// or against a bit-exact integer model
module ray_triangle_closest_hit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE = 65536;
    localparam logic [rtch_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    // smallest |det| that passes the 1e-8 test at 3*16 fraction bits
    localparam logic [127:0] DET_FLOOR = ((128'd1 << 48) + 128'd99999999) / 128'd100000000;
    localparam int RANDOM_ITEMS = 1830;
    localparam int SETTLE = 120;

    typedef struct {
        logic [31:0] v[9];
        logic [15:0] face;
        logic        last;
    } tri_t;

    typedef struct {
        logic        hit;
        logic [30:0] t_hit;
        logic [16:0] u;
        logic [16:0] v;
        logic [15:0] face;
    } hit_t;

    typedef enum logic {ROW_CFG, ROW_TRI} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [rtch_pkg::CFG_IDX_W-1:0]  idx;
        logic [31:0]                     data;
        tri_t                            tri_item;
        logic                            typed;
        hit_t                            want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rtch_pkg::CW-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic signed [rtch_pkg::CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [rtch_pkg::FACE_W-1:0] face_tag;
    logic final_triangle;
    logic out_valid;
    logic out_ready;
    logic hit_found;
    logic [rtch_pkg::TQW-1:0] hit_distance;
    logic [rtch_pkg::UQW-1:0] bary_u;
    logic [rtch_pkg::UQW-1:0] bary_v;
    logic [rtch_pkg::FACE_W-1:0] hit_face;

    ray_triangle_closest_hit uut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ray registers and kept hit of the model
    logic [31:0] ray_org[3];
    logic [31:0] ray_dir[3];
    logic [30:0] ray_maxd;
    hit_t        nearest;

    hit_t  expected_hits[$];
    row_t  table_rows[$];
    int    mismatches;
    int    triangles_sent;
    int    results_seen;
    int    hits_seen;
    bit    no_gaps;

    function automatic void reset_ray();
        ray_org  = '{32'd0, 32'd0, 32'd0};
        ray_dir  = '{32'd65536, 32'd0, 32'd0};
        ray_maxd = 31'h7FFFFFFF;
        nearest  = '{1'b0, 31'd0, 17'd0, 17'd0, 16'd0};
    endfunction

    function automatic void model_cfg(logic [rtch_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            rtch_pkg::REG_ORG_X: ray_org[0] = data;
            rtch_pkg::REG_ORG_Y: ray_org[1] = data;
            rtch_pkg::REG_ORG_Z: ray_org[2] = data;
            rtch_pkg::REG_DIR_X: ray_dir[0] = data;
            rtch_pkg::REG_DIR_Y: ray_dir[1] = data;
            rtch_pkg::REG_DIR_Z: ray_dir[2] = data;
            rtch_pkg::REG_MAXD:  ray_maxd = data[30:0];
            default: ;
        endcase
    endfunction

    // exact moller-trumbore test, keeps the strictly nearest hit
    function automatic void predict_tri(tri_t t);
        logic signed [127:0] a[3], b[3], c[3], o[3], d[3];
        logic signed [127:0] e1[3], e2[3], s[3], h[3], q[3];
        logic signed [127:0] det, un, vn, tn;
        logic [127:0] tq, uq, vq;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = $signed(t.v[i]);
            b[i] = $signed(t.v[3 + i]);
            c[i] = $signed(t.v[6 + i]);
            o[i] = $signed(ray_org[i]);
            d[i] = $signed(ray_dir[i]);
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            s[i]  = o[i] - a[i];
        end
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        un  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0)
        begin
            det = -det;
            un  = -un;
            vn  = -vn;
            tn  = -tn;
        end
        if ($unsigned(det) < DET_FLOOR)
            return;
        if (un < 0 || un > det)
            return;
        if (vn < 0 || un + vn > det)
            return;
        if (tn < 0 || (tn <<< 16) < det)
            return;
        tq = $unsigned(tn <<< 16) / $unsigned(det);
        if (tq >= {97'd0, ray_maxd})
            return;
        if (nearest.hit && tq >= {97'd0, nearest.t_hit})
            return;
        uq = $unsigned(un <<< 16) / $unsigned(det);
        vq = $unsigned(vn <<< 16) / $unsigned(det);
        nearest.hit   = 1'b1;
        nearest.t_hit = tq[30:0];
        nearest.u     = uq[16:0];
        nearest.v     = vq[16:0];
        nearest.face  = t.face;
    endfunction

    // register write, model updated as the write is driven, then a wait with cfg_we low
    task automatic write_reg(logic [rtch_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        model_cfg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every result is back and the unit is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one triangle transfer; a typed expectation replaces the model's result
    task automatic send_tri(tri_t t, logic typed, hit_t want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {ax, ay, az, bx, by, bz, cx, cy, cz} <=
            {t.v[0], t.v[1], t.v[2], t.v[3], t.v[4], t.v[5], t.v[6], t.v[7], t.v[8]};
        face_tag       <= t.face;
        final_triangle <= t.last;
        do
            @(posedge clk);
        while (!in_ready);
        triangles_sent++;
        predict_tri(t);
        if (t.last)
        begin
            expected_hits.insert(expected_hits.size(), typed ? want : nearest);
            nearest = '{1'b0, 31'd0, 17'd0, 17'd0, 16'd0};
        end
    endtask

    function automatic tri_t mk_tri(int ax_u, int ay_u, int az_u, int bx_u, int by_u,
                                    int bz_u, int cx_u, int cy_u, int cz_u,
                                    logic [15:0] face, logic last);
        tri_t t;
        t.v = '{ax_u * ONE, ay_u * ONE, az_u * ONE, bx_u * ONE, by_u * ONE,
                bz_u * ONE, cx_u * ONE, cy_u * ONE, cz_u * ONE};
        t.face = face;
        t.last = last;
        return t;
    endfunction

    function automatic void add_tri(tri_t t, logic typed, hit_t want);
        row_t r;
        r.kind = ROW_TRI;
        r.tri_item = t;
        r.typed = typed;
        r.want = want;
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic void add_cfg(logic [rtch_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.typed = 1'b0;
        table_rows.insert(table_rows.size(), r);
    endfunction

    // random triangle: mostly placed around a point of the ray, some noise
    function automatic tri_t rand_tri(logic last);
        tri_t t;
        logic [31:0] p[3];
        int k;
        int span;
        k = $urandom_range(1, 40);
        span = ($urandom_range(0, 3) == 0) ? 8 * ONE : 4 * ONE;
        for (int i = 0; i < 3; i++)
            p[i] = ray_org[i] + ray_dir[i] * k;
        for (int i = 0; i < 9; i++)
        begin
            if ($urandom_range(0, 9) < 2)
                t.v[i] = $urandom;
            else
                t.v[i] = p[i % 3] + $urandom_range(0, 2 * span) - span;
        end
        t.face = $urandom;
        t.last = last;
        return t;
    endfunction

    function automatic logic [31:0] rand_dir_comp(bit wide_range);
        if (wide_range)
            return $urandom;
        return $urandom_range(0, 4 * ONE) - 2 * ONE;
    endfunction

    // stimulus
    initial
    begin
        hit_t miss, want;
        tri_t t, prev;
        int sent_random;
        int phase;
        int mesh;
        logic [31:0] lo, hi;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        in_valid       <= 1'b0;
        {ax, ay, az, bx, by, bz, cx, cy, cz} <= '0;
        face_tag       <= '0;
        final_triangle <= 1'b0;
        mismatches = 0;
        triangles_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        no_gaps = 1'b0;
        reset_ray();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, default ray along +x from the origin
        miss = '{1'b0, 31'd0, 17'd0, 17'd0, 16'd0};
        lo = 32'h80000000;
        hi = 32'h7FFFFFFF;
        add_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 1'b1), 1'b1, miss);
        want = '{1'b1, 31'd131072, 17'd0, 17'd0, 16'hFFFF};
        add_tri(mk_tri(2, 0, 0, 2, 1, 0, 2, 0, 1, 16'hFFFF, 1'b1), 1'b1, want);
        // equal distances: the first tag stays
        add_tri(mk_tri(2, 0, 0, 2, 1, 0, 2, 0, 1, 16'd1, 1'b0), 1'b0, miss);
        want.face = 16'd1;
        add_tri(mk_tri(2, 0, 0, 2, 1, 0, 2, 0, 1, 16'd2, 1'b1), 1'b1, want);
        // behind the origin, at the origin, off the triangle
        add_tri(mk_tri(-2, 0, 0, -2, 1, 0, -2, 0, 1, 16'd3, 1'b1), 1'b1, miss);
        add_tri(mk_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 16'd4, 1'b1), 1'b1, miss);
        add_tri(mk_tri(2, 5, 5, 2, 6, 5, 2, 5, 6, 16'd5, 1'b1), 1'b1, miss);
        // coordinate extremes
        t.v = '{lo, lo, lo, lo, lo, lo, lo, lo, lo};
        t.face = 16'd6;
        t.last = 1'b1;
        add_tri(t, 1'b1, miss);
        t.v = '{hi, hi, hi, hi, hi, hi, hi, hi, hi};
        add_tri(t, 1'b1, miss);
        t.v = '{lo, hi, lo, hi, lo, hi, lo, lo, hi};
        add_tri(t, 1'b0, miss);
        // nearer hit replaces, further one does not
        add_tri(mk_tri(3, -1, -1, 3, 2, -1, 3, -1, 2, 16'd7, 1'b0), 1'b0, miss);
        add_tri(mk_tri(1, -1, -1, 1, 2, -1, 1, -1, 2, 16'd8, 1'b0), 1'b0, miss);
        add_tri(mk_tri(2, -1, -1, 2, 2, -1, 2, -1, 2, 16'd9, 1'b1), 1'b0, miss);
        // hit on an edge, v exactly zero
        add_tri(mk_tri(2, -1, 0, 2, 1, 0, 2, 0, 1, 16'd10, 1'b1), 1'b0, miss);
        // distance limit equal to the hit, then zero
        add_cfg(rtch_pkg::REG_MAXD, 32'd131072);
        add_tri(mk_tri(2, 0, 0, 2, 1, 0, 2, 0, 1, 16'd11, 1'b1), 1'b1, miss);
        add_tri(mk_tri(1, -1, -1, 1, 2, -1, 1, -1, 2, 16'd12, 1'b1), 1'b0, miss);
        add_cfg(rtch_pkg::REG_MAXD, 32'd0);
        add_tri(mk_tri(1, -1, -1, 1, 2, -1, 1, -1, 2, 16'd13, 1'b1), 1'b1, miss);
        // unused register index, then a ray along -x
        add_cfg(REG_SPARE, 32'hFFFFFFFF);
        add_cfg(rtch_pkg::REG_MAXD, 32'h7FFFFFFF);
        add_cfg(rtch_pkg::REG_DIR_X, 32'hFFFF0000);
        want = '{1'b1, 31'd131072, 17'd0, 17'd0, 16'd14};
        add_tri(mk_tri(-2, 0, 0, -2, 1, 0, -2, 0, 1, 16'd14, 1'b1), 1'b1, want);

        foreach (table_rows[i])
        begin
            if (table_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(table_rows[i].idx, table_rows[i].data);
            end
            else
                send_tri(table_rows[i].tri_item, table_rows[i].typed, table_rows[i].want);
        end

        // random phases, each with its own ray
        sent_random = 0;
        phase = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            drain();
            no_gaps = (phase % 4 == 3);
            case (phase % 6)
                0:
                begin
                    // extreme origin
                    write_reg(rtch_pkg::REG_ORG_X, hi);
                    write_reg(rtch_pkg::REG_ORG_Y, lo);
                    write_reg(rtch_pkg::REG_ORG_Z, hi);
                end
                default:
                begin
                    write_reg(rtch_pkg::REG_ORG_X, $urandom_range(0, 64 * ONE) - 32 * ONE);
                    write_reg(rtch_pkg::REG_ORG_Y, $urandom_range(0, 64 * ONE) - 32 * ONE);
                    write_reg(rtch_pkg::REG_ORG_Z, $urandom_range(0, 64 * ONE) - 32 * ONE);
                end
            endcase
            write_reg(rtch_pkg::REG_DIR_X, rand_dir_comp(phase % 5 == 4));
            write_reg(rtch_pkg::REG_DIR_Y, rand_dir_comp(phase % 5 == 4));
            write_reg(rtch_pkg::REG_DIR_Z, rand_dir_comp(phase % 5 == 4));
            case (phase % 4)
                0: write_reg(rtch_pkg::REG_MAXD, 32'h7FFFFFFF);
                1: write_reg(rtch_pkg::REG_MAXD,
                             (phase == 1) ? 32'd0 : $urandom_range(ONE, 40 * ONE));
                2: write_reg(rtch_pkg::REG_MAXD, $urandom & 32'h7FFFFFFF);
                default: write_reg(rtch_pkg::REG_MAXD, 32'h7FFFFFFF);
            endcase
            for (int n = 0; n < 183 && sent_random < RANDOM_ITEMS; )
            begin
                mesh = $urandom_range(1, 6);
                for (int m = 0; m < mesh; m++)
                begin
                    if (m > 0 && $urandom_range(0, 7) == 0)
                    begin
                        // repeated triangle under another tag
                        t = prev;
                        t.face = $urandom;
                        t.last = (m == mesh - 1);
                    end
                    else
                        t = rand_tri(m == mesh - 1);
                    prev = t;
                    send_tri(t, 1'b0, miss);
                    n++;
                    sent_random++;
                end
            end
            phase++;
        end

        drain();
        $display("ran %0d triangles over %0d ray settings", triangles_sent, phase + 4);
        $display("checked %0d nearest-hit results, %0d with a hit", results_seen, hits_seen);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls, each transfer checked against the oldest prediction
    initial
    begin
        int stall;
        hit_t exp_hit;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            results_seen++;
            if (hit_found)
                hits_seen++;
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit %0b t %0d u %0d v %0d face %0d",
                             hit_found, hit_distance, bary_u, bary_v, hit_face);
            end
            else
            begin
                exp_hit = expected_hits.pop_front();
                if (hit_found !== exp_hit.hit || hit_distance !== exp_hit.t_hit ||
                    bary_u !== exp_hit.u || bary_v !== exp_hit.v ||
                    hit_face !== exp_hit.face)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp hit %0b t %0d u %0d v %0d face %0d, got hit %0b t %0d u %0d v %0d face %0d",
                                 exp_hit.hit, exp_hit.t_hit, exp_hit.u, exp_hit.v,
                                 exp_hit.face, hit_found, hit_distance, bary_u,
                                 bary_v, hit_face);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
